FILE: hw/rtl/sdt_pkg.sv
// ----------------------------------------------------------------------------
// sdt_pkg
// Shared types for the truncating signed divider: result status codes and
// the per-item control flags carried down the pipeline.
// ----------------------------------------------------------------------------
package sdt_pkg;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_DIV_ZERO = 2'd1,
		STATUS_OVERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic    neg_q;
		logic    neg_r;
		status_t status;
	} ctl_t;

endpackage

FILE: hw/rtl/sdt_pre.sv
// ----------------------------------------------------------------------------
// sdt_pre
// Input stage: operand magnitudes, sign flags and special case detection.
// ----------------------------------------------------------------------------
module sdt_pre import sdt_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         valid,
	output logic                         stall,
	input  logic signed [DATA_WIDTH-1:0] dividend,
	input  logic signed [DATA_WIDTH-1:0] divisor,
	output logic                         valid_s1,
	input  logic                         dn_stall,
	output logic        [DATA_WIDTH-1:0] ma_s1,
	output logic        [DATA_WIDTH-1:0] mb_s1,
	output ctl_t                         ctl_s1
);

	logic                  neg_a;
	logic                  neg_b;
	logic                  is_zero;
	logic                  is_ovf;
	logic [DATA_WIDTH-1:0] a_u;
	logic [DATA_WIDTH-1:0] b_u;
	ctl_t                  ctl_d;

	assign stall   = valid_s1 && dn_stall;
	assign a_u     = dividend;
	assign b_u     = divisor;
	assign neg_a   = a_u[DATA_WIDTH-1];
	assign neg_b   = b_u[DATA_WIDTH-1];
	assign is_zero = (b_u == '0);
	assign is_ovf  = (a_u == {1'b1, {(DATA_WIDTH-1){1'b0}}}) && (b_u == '1);

	always_comb begin
		ctl_d.neg_q = (neg_a ^ neg_b) && !is_zero;
		ctl_d.neg_r = neg_a;
		if (is_zero) begin
			ctl_d.status = STATUS_DIV_ZERO;
		end else if (is_ovf) begin
			ctl_d.status = STATUS_OVERFLOW;
		end else begin
			ctl_d.status = STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall && valid) begin
			ma_s1  <= neg_a ? ('0 - a_u) : a_u;
			mb_s1  <= neg_b ? ('0 - b_u) : b_u;
			ctl_s1 <= ctl_d;
		end
	end

endmodule

FILE: hw/rtl/sdt_step.sv
// ----------------------------------------------------------------------------
// sdt_step
// One restoring division stage: shifts in one dividend bit, trial subtract,
// produces one quotient bit.
// ----------------------------------------------------------------------------
module sdt_step import sdt_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid,
	output logic                  stall,
	input  logic [DATA_WIDTH-1:0] rem,
	input  logic [DATA_WIDTH-1:0] quo,
	input  logic [DATA_WIDTH-1:0] mb,
	input  ctl_t                  ctl,
	output logic                  valid_s2,
	input  logic                  dn_stall,
	output logic [DATA_WIDTH-1:0] rem_s2,
	output logic [DATA_WIDTH-1:0] quo_s2,
	output logic [DATA_WIDTH-1:0] mb_s2,
	output ctl_t                  ctl_s2
);

	logic [DATA_WIDTH:0] trial;
	logic [DATA_WIDTH:0] diff;
	logic                ge;

	assign stall = valid_s2 && dn_stall;
	assign trial = {rem, quo[DATA_WIDTH-1]};
	assign diff  = trial - {1'b0, mb};
	assign ge    = !diff[DATA_WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!stall) begin
			valid_s2 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall && valid) begin
			rem_s2 <= ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
			quo_s2 <= {quo[DATA_WIDTH-2:0], ge};
			mb_s2  <= mb;
			ctl_s2 <= ctl;
		end
	end

	// partial remainder stays below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (mb_s2 != '0)) |-> (rem_s2 < mb_s2))
		else $error("partial remainder not below divisor");

endmodule

FILE: hw/rtl/sdt_post.sv
// ----------------------------------------------------------------------------
// sdt_post
// Output stage: sign correction of quotient and remainder, result register.
// ----------------------------------------------------------------------------
module sdt_post import sdt_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         valid,
	output logic                         stall,
	input  logic        [DATA_WIDTH-1:0] rem,
	input  logic        [DATA_WIDTH-1:0] quo,
	input  ctl_t                         ctl,
	output logic                         valid_s3,
	input  logic                         dn_stall,
	output logic signed [DATA_WIDTH-1:0] quotient_s3,
	output logic signed [DATA_WIDTH-1:0] remainder_s3,
	output logic        [1:0]            status_s3
);

	assign stall = valid_s3 && dn_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (!stall) begin
			valid_s3 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall && valid) begin
			quotient_s3  <= ctl.neg_q ? ('0 - quo) : quo;
			remainder_s3 <= ctl.neg_r ? ('0 - rem) : rem;
			status_s3    <= ctl.status;
		end
	end

	a_zero_quo: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && (status_s3 == STATUS_DIV_ZERO)) |-> (quotient_s3 == '1))
		else $error("divide by zero quotient not all ones");

	a_ovf_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && (status_s3 == STATUS_OVERFLOW)) |-> (remainder_s3 == '0))
		else $error("overflow remainder not zero");

	a_ovf_quo: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && (status_s3 == STATUS_OVERFLOW))
		|-> (quotient_s3 == {1'b1, {(DATA_WIDTH-1){1'b0}}}))
		else $error("overflow quotient not most negative");

endmodule

FILE: hw/rtl/signed_divider_trunc_top.sv
// ----------------------------------------------------------------------------
// signed_divider_trunc_top
// Pipelined signed divider, quotient truncated toward zero, remainder with
// the sign of the dividend; flags divide by zero and overflow.
//
//   channel  handshake              payload
//   req      req_valid, req_stall   dividend, divisor
//   rsp      rsp_valid, rsp_stall   quotient, remainder, status
//
// one item per cycle while rsp_stall is low; stages run sdt_pre, the sdt_step chain, then sdt_post
// one restoring step per sdt_step stage, one quotient bit each
// arst_n clears all stage valid bits, payload registers are not reset
// each stage holds while it is full and the next one stalls, so bubbles
// are squeezed out and items are taken while a result waits
// ----------------------------------------------------------------------------
module signed_divider_trunc_top import sdt_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic signed [DATA_WIDTH-1:0] dividend,
	input  logic signed [DATA_WIDTH-1:0] divisor,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic signed [DATA_WIDTH-1:0] quotient,
	output logic signed [DATA_WIDTH-1:0] remainder,
	output logic        [1:0]            status
);

	logic                  valid_w [DATA_WIDTH+1];
	logic                  stall_w [DATA_WIDTH+1];
	logic [DATA_WIDTH-1:0] rem_w   [DATA_WIDTH+1];
	logic [DATA_WIDTH-1:0] quo_w   [DATA_WIDTH+1];
	logic [DATA_WIDTH-1:0] mb_w    [DATA_WIDTH+1];
	ctl_t                  ctl_w   [DATA_WIDTH+1];

	assign rem_w[0] = '0;

	sdt_pre #(.DATA_WIDTH(DATA_WIDTH)) u_pre (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (req_valid),
		.stall    (req_stall),
		.dividend (dividend),
		.divisor  (divisor),
		.valid_s1 (valid_w[0]),
		.dn_stall (stall_w[0]),
		.ma_s1    (quo_w[0]),
		.mb_s1    (mb_w[0]),
		.ctl_s1   (ctl_w[0])
	);

	for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_step
		sdt_step #(.DATA_WIDTH(DATA_WIDTH)) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.valid    (valid_w[i]),
			.stall    (stall_w[i]),
			.rem      (rem_w[i]),
			.quo      (quo_w[i]),
			.mb       (mb_w[i]),
			.ctl      (ctl_w[i]),
			.valid_s2 (valid_w[i+1]),
			.dn_stall (stall_w[i+1]),
			.rem_s2   (rem_w[i+1]),
			.quo_s2   (quo_w[i+1]),
			.mb_s2    (mb_w[i+1]),
			.ctl_s2   (ctl_w[i+1])
		);
	end

	sdt_post #(.DATA_WIDTH(DATA_WIDTH)) u_post (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid        (valid_w[DATA_WIDTH]),
		.stall        (stall_w[DATA_WIDTH]),
		.rem          (rem_w[DATA_WIDTH]),
		.quo          (quo_w[DATA_WIDTH]),
		.ctl          (ctl_w[DATA_WIDTH]),
		.valid_s3     (rsp_valid),
		.dn_stall     (rsp_stall),
		.quotient_s3  (quotient),
		.remainder_s3 (remainder),
		.status_s3    (status)
	);

endmodule
